>>> rtl/core/sme_pkg.sv
// Package for the schedule makespan evaluator: request/result structs,
// operation codes and the evaluation sequencer state type. No dependencies.
`timescale 1ns / 1ps
package sme_pkg;

    localparam int TIME_W = 24;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // Alternatives per step; the choice reduction is built for this count
    localparam int MAX_ALTS = 4;

    typedef enum logic [1:0] {
        OP_ROUTE  = 2'd0,
        OP_COUNT  = 2'd1,
        OP_TRAVEL = 2'd2,
        OP_EVAL   = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  job;
        logic [3:0]  step_index;
        logic [7:0]  alt_choice;
        logic [3:0]  machine;
        logic [3:0]  to_machine;
        logic [15:0] value;
        logic [1:0]  robot;
        logic        last;
    } req_t;

    typedef struct packed {
        logic [23:0] makespan;
        logic [23:0] finish_time;
        logic [3:0]  chosen_machine;
        logic        sequence_done;
        logic        bad_step;
    } res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_ROUTE,
        ST_TRAVEL,
        ST_UPDATE,
        ST_CLEAR,
        ST_OUT
    } state_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] max_t(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

>>> rtl/core/schedule_makespan_evaluator.sv
// Schedule makespan evaluator top level: route/travel memories and the
// evaluation sequencer. Depends on sme_pkg.
`timescale 1ns / 1ps
// Requests load the route tables (operation 0 route entry, 1 alternative
// count, 2 travel time) or evaluate one job step (operation 3). Loads are
// written when taken and give no result. An evaluate request walks a short
// sequence: read the step's alternative count, reduce the choice modulo it
// (at most four alternatives: a mask for two and four, a base-4 digit sum for
// three), read the route entry, read the two travel times (robot to job, job
// to machine) from one dual-read travel memory, then update the machine,
// robot and job times. Each of those reads and the update is registered in
// its own state; a clear state and then an output state, which raises the
// result valid, follow. The next request is taken only once the sequence is
// back in idle and the result register is free, so evaluates never overlap.
// An evaluate request with last set clears the run state afterwards; these
// small files live in flip-flops. The route and travel memories are not
// cleared: reading an entry never written returns whatever it holds.
module schedule_makespan_evaluator
    import sme_pkg::*;
#(
    parameter int MAX_JOBS     = 16,
    parameter int MAX_STEPS    = 16,
    parameter int MAX_MACHINES = 16,
    parameter int MAX_ROBOTS   = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output res_t m_data
);

    localparam int JW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int SW  = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int AW  = (MAX_ALTS > 1) ? $clog2(MAX_ALTS) : 1;
    localparam int MW  = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
    localparam int RW  = (MAX_ROBOTS > 1) ? $clog2(MAX_ROBOTS) : 1;
    localparam int CW  = $clog2(MAX_ALTS + 1);
    localparam int DW  = $clog2(MAX_STEPS + 1);
    localparam int RTD = MAX_JOBS * MAX_STEPS * MAX_ALTS;
    localparam int CTD = MAX_JOBS * MAX_STEPS;
    localparam int TTD = MAX_MACHINES * MAX_MACHINES;
    localparam int RTA = $clog2(RTD) > 0 ? $clog2(RTD) : 1;
    localparam int CTA = $clog2(CTD) > 0 ? $clog2(CTD) : 1;
    localparam int TTA = $clog2(TTD) > 0 ? $clog2(TTD) : 1;

    // Memories
    logic [3+16:0]  route_mem [RTD];
    logic [15:0]    travel_mem [TTD];
    logic [CW-1:0]  count_mem [CTD];
    logic [CTD-1:0] count_vld_reg;

    // Run state in flip-flops
    logic [TIME_W-1:0] mach_free_reg [MAX_MACHINES];
    logic [TIME_W-1:0] rob_free_reg [MAX_ROBOTS];
    logic [MW-1:0]     rob_loc_reg [MAX_ROBOTS];
    logic [MW-1:0]     job_loc_reg [MAX_JOBS];
    logic [TIME_W-1:0] job_rdy_reg [MAX_JOBS];
    logic [DW-1:0]     job_done_reg [MAX_JOBS];
    logic [TIME_W-1:0] span_reg;

    state_t state_reg, state_next;
    req_t   req_reg;
    res_t   res_reg;
    logic   m_valid_reg;

    logic [CW-1:0]     cnt_rd;
    logic              cnt_vld_rd;
    logic [19:0]       route_rd;
    logic [15:0]       trav_a_rd, trav_b_rd;
    logic [CTA-1:0]    cidx_reg;
    logic [MW-1:0]     mach_reg;
    logic [15:0]       ptime_reg;
    logic              bad_reg;

    // Decode of the request in flight
    logic [JW-1:0] ejob;
    logic [RW-1:0] erob;
    logic          job_ok;
    assign ejob   = req_reg.job[JW-1:0];
    // Robot index wraps at MAX_ROBOTS; a two-bit index needs one subtract at most
    assign erob   = (MAX_ROBOTS == 1) ? '0
                  : (32'(req_reg.robot) < MAX_ROBOTS) ? RW'(req_reg.robot)
                  : RW'(32'(req_reg.robot) - MAX_ROBOTS);
    assign job_ok = 32'(req_reg.job) < MAX_JOBS;

    logic accept;
    assign s_ready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = res_reg;

    // Load address checks
    logic ld_route_ok, ld_count_ok, ld_trav_ok;
    assign ld_route_ok = 32'(s_data.job) < MAX_JOBS && 32'(s_data.step_index) < MAX_STEPS
                      && 32'(s_data.alt_choice) < MAX_ALTS && 32'(s_data.machine) < MAX_MACHINES;
    assign ld_count_ok = 32'(s_data.job) < MAX_JOBS && 32'(s_data.step_index) < MAX_STEPS;
    assign ld_trav_ok  = 32'(s_data.machine) < MAX_MACHINES
                      && 32'(s_data.to_machine) < MAX_MACHINES;

    logic [RTA-1:0] ld_ridx;
    logic [CTA-1:0] ld_cidx;
    logic [TTA-1:0] ld_tidx;
    assign ld_cidx = CTA'(32'(s_data.job) * MAX_STEPS + 32'(s_data.step_index));
    assign ld_ridx = RTA'(32'(ld_cidx) * MAX_ALTS + 32'(s_data.alt_choice));
    assign ld_tidx = TTA'(32'(s_data.machine) * MAX_MACHINES + 32'(s_data.to_machine));

    // Count entry of the job's next step
    logic [DW-1:0]  done_cur;
    logic [CTA-1:0] cidx_c;
    assign done_cur = job_done_reg[ejob];
    assign cidx_c   = CTA'(32'(ejob) * MAX_STEPS + 32'(done_cur[SW-1:0]));

    // Reduced choice from the fetched count (count at most MAX_ALTS)
    logic [CW-1:0] cnt_eff;
    logic [AW-1:0] rem;
    logic [3:0]    dsum;
    logic [2:0]    dfold;
    logic [1:0]    mod3;
    assign cnt_eff = cnt_vld_rd ? cnt_rd : '0;
    // Residue mod 3: sum the base-4 digits, fold once more, subtract at most twice
    assign dsum  = 4'(req_reg.alt_choice[1:0]) + 4'(req_reg.alt_choice[3:2])
                 + 4'(req_reg.alt_choice[5:4]) + 4'(req_reg.alt_choice[7:6]);
    assign dfold = 3'(dsum[1:0]) + 3'(dsum[3:2]);
    always_comb begin
        if (dfold >= 3'd6) begin
            mod3 = 2'(dfold - 3'd6);
        end else if (dfold >= 3'd3) begin
            mod3 = 2'(dfold - 3'd3);
        end else begin
            mod3 = dfold[1:0];
        end
    end
    always_comb begin
        case (cnt_eff)
            CW'(2):  rem = AW'(req_reg.alt_choice[0]);
            CW'(3):  rem = AW'(mod3);
            CW'(4):  rem = AW'(req_reg.alt_choice[1:0]);
            default: rem = '0;
        endcase
    end

    // Route address after reduction
    logic [RTA-1:0] ev_ridx;
    assign ev_ridx = RTA'(32'(cidx_reg) * MAX_ALTS + 32'(rem));

    // Travel addresses: robot location to job, job to machine
    logic [MW-1:0]  here;
    logic [TTA-1:0] tidx_a, tidx_b;
    logic [MW-1:0]  rm_m;
    assign here   = job_loc_reg[ejob];
    assign rm_m   = (32'(route_rd[19:16]) < MAX_MACHINES) ? route_rd[16+MW-1:16] : '0;
    assign tidx_a = TTA'(32'(rob_loc_reg[erob]) * MAX_MACHINES + 32'(here));
    assign tidx_b = TTA'(32'(here) * MAX_MACHINES + 32'(rm_m));

    // Count / memory access: write on load, read on evaluate steps
    always_ff @(posedge aclk) begin
        if (accept && s_data.operation == OP_ROUTE && ld_route_ok) begin
            route_mem[ld_ridx] <= {s_data.machine, s_data.value};
        end
        if (accept && s_data.operation == OP_TRAVEL && ld_trav_ok) begin
            travel_mem[ld_tidx] <= s_data.value;
        end
        if (accept && s_data.operation == OP_COUNT && ld_count_ok) begin
            count_mem[ld_cidx] <= (32'(s_data.value) > MAX_ALTS) ? CW'(MAX_ALTS)
                                                                 : CW'(s_data.value);
        end
        cnt_rd     <= count_mem[cidx_c];
        cnt_vld_rd <= count_vld_reg[cidx_c];
        route_rd   <= route_mem[ev_ridx];
        trav_a_rd  <= travel_mem[tidx_a];
        trav_b_rd  <= travel_mem[tidx_b];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_vld_reg <= '0;
        end else if (accept && s_data.operation == OP_COUNT && ld_count_ok) begin
            count_vld_reg[ld_cidx] <= 1'b1;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (accept && s_data.operation == OP_EVAL) state_next = ST_COUNT;
            ST_COUNT:  state_next = ST_ROUTE;
            ST_ROUTE:  state_next = ST_TRAVEL;
            ST_TRAVEL: state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_CLEAR;
            ST_CLEAR:  state_next = ST_OUT;
            ST_OUT:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Update arithmetic
    logic [TIME_W-1:0] arrive, depart, rob_new, mfin;
    assign arrive  = sat_add(rob_free_reg[erob], TIME_W'(trav_a_rd));
    assign depart  = max_t(job_rdy_reg[ejob], arrive);
    assign rob_new = sat_add(depart, TIME_W'(trav_b_rd));
    always_comb begin
        if (mach_reg == here) begin
            mfin = sat_add(mach_free_reg[mach_reg], TIME_W'(ptime_reg));
        end else begin
            mfin = sat_add(max_t(mach_free_reg[mach_reg], rob_new), TIME_W'(ptime_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            span_reg    <= '0;
            for (int i = 0; i < MAX_MACHINES; i++) mach_free_reg[i] <= '0;
            for (int i = 0; i < MAX_ROBOTS; i++) begin
                rob_free_reg[i] <= '0;
                rob_loc_reg[i]  <= '0;
            end
            for (int i = 0; i < MAX_JOBS; i++) begin
                job_loc_reg[i]  <= '0;
                job_rdy_reg[i]  <= '0;
                job_done_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (accept) req_reg <= s_data;
                end
                ST_COUNT: begin
                    // Count read launches now; flag a job beyond range or out of steps
                    bad_reg  <= !job_ok || 32'(done_cur) >= MAX_STEPS;
                    cidx_reg <= cidx_c;
                end
                ST_ROUTE: begin
                    // Count arrives; route read launches from the reduced choice
                    if (cnt_eff == '0) bad_reg <= 1'b1;
                end
                ST_TRAVEL: begin
                    // Route entry arrives; travel reads launch from it
                    mach_reg  <= rm_m;
                    ptime_reg <= route_rd[15:0];
                end
                ST_UPDATE: begin
                    res_reg.sequence_done <= req_reg.last;
                    res_reg.bad_step      <= bad_reg;
                    if (bad_reg) begin
                        res_reg.makespan       <= span_reg;
                        res_reg.finish_time    <= '0;
                        res_reg.chosen_machine <= '0;
                    end else begin
                        if (mach_reg != here) begin
                            rob_free_reg[erob] <= rob_new;
                            rob_loc_reg[erob]  <= mach_reg;
                        end
                        mach_free_reg[mach_reg] <= mfin;
                        job_rdy_reg[ejob]       <= mfin;
                        job_loc_reg[ejob]       <= mach_reg;
                        job_done_reg[ejob]      <= job_done_reg[ejob] + 1'b1;
                        span_reg                <= max_t(span_reg, mfin);
                        res_reg.makespan        <= max_t(span_reg, mfin);
                        res_reg.finish_time     <= mfin;
                        res_reg.chosen_machine  <= 4'(mach_reg);
                    end
                end
                ST_CLEAR: begin
                    // Drop the run state at the end of a sequence
                    if (req_reg.last) begin
                        span_reg <= '0;
                        for (int i = 0; i < MAX_MACHINES; i++) mach_free_reg[i] <= '0;
                        for (int i = 0; i < MAX_ROBOTS; i++) begin
                            rob_free_reg[i] <= '0;
                            rob_loc_reg[i]  <= '0;
                        end
                        for (int i = 0; i < MAX_JOBS; i++) begin
                            job_loc_reg[i]  <= '0;
                            job_rdy_reg[i]  <= '0;
                            job_done_reg[i] <= '0;
                        end
                    end
                end
                ST_OUT: begin
                    m_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

endmodule

>>> dv/schedule_makespan_evaluator_checker.sv
// Checker for the schedule makespan evaluator: watches both channels, predicts
// each result from accepted requests and compares field by field. Depends on sme_pkg.
`timescale 1ns / 1ps
module schedule_makespan_evaluator_checker
    import sme_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    input  logic s_ready,
    input  req_t s_data,
    input  logic m_valid,
    input  logic m_ready,
    input  res_t m_data,
    output int   fail_count,
    output int   pending,
    output int   results_seen
);
    localparam int NJ = 16, NS = 16, NA = 4, NM = 16, NR = 4;

    logic [3:0]  rt_mach [NJ*NS*NA];
    logic [15:0] rt_time [NJ*NS*NA];
    logic [2:0]  alt_cnt [NJ*NS];
    logic [15:0] travel  [NM*NM];
    logic [23:0] mach_free [NM];
    logic [23:0] robot_free [NR];
    logic [3:0]  robot_loc [NR];
    logic [3:0]  job_loc [NJ];
    logic [23:0] job_ready [NJ];
    logic [4:0]  job_done [NJ];
    logic [23:0] span;
    res_t        expected_q[$];

    function automatic logic [23:0] tsum(logic [23:0] a, logic [23:0] b);
        logic [24:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[24] ? 24'hFFFFFF : s[23:0];
    endfunction

    function automatic logic [23:0] tmax(logic [23:0] a, logic [23:0] b);
        return a > b ? a : b;
    endfunction

    task automatic clear_run();
        for (int i = 0; i < NM; i++) mach_free[i] = '0;
        for (int i = 0; i < NR; i++) begin
            robot_free[i] = '0;
            robot_loc[i] = '0;
        end
        for (int i = 0; i < NJ; i++) begin
            job_loc[i] = '0;
            job_ready[i] = '0;
            job_done[i] = '0;
        end
        span = '0;
    endtask

    task automatic predict_request(req_t r);
        int idx, sel, m, here, rl;
        logic [23:0] arrive, depart;
        res_t e;
        case (op_t'(r.operation))
            OP_ROUTE: begin
                if (r.alt_choice < NA) begin
                    idx = (r.job * NS + r.step_index) * NA + r.alt_choice;
                    rt_mach[idx] = r.machine;
                    rt_time[idx] = r.value;
                end
            end
            OP_COUNT: alt_cnt[r.job*NS+r.step_index] = (r.value > NA) ? 3'(NA) : r.value[2:0];
            OP_TRAVEL: travel[r.machine*NM+r.to_machine] = r.value;
            default: begin
                e = '0;
                e.bad_step = 1'b1;
                if (job_done[r.job] < NS && alt_cnt[r.job*NS+job_done[r.job]] != 0) begin
                    e.bad_step = 1'b0;
                    sel = r.alt_choice % alt_cnt[r.job*NS+job_done[r.job]];
                    idx = (r.job * NS + job_done[r.job]) * NA + sel;
                    m = int'(rt_mach[idx]);
                    here = int'(job_loc[r.job]);
                    if (m == here) begin
                        mach_free[m] = tsum(mach_free[m], 24'(rt_time[idx]));
                    end else begin
                        rl = int'(robot_loc[r.robot]);
                        arrive = tsum(robot_free[r.robot], 24'(travel[rl*NM+here]));
                        depart = tmax(job_ready[r.job], arrive);
                        robot_free[r.robot] = tsum(depart, 24'(travel[here*NM+m]));
                        robot_loc[r.robot] = 4'(m);
                        mach_free[m] = tsum(tmax(mach_free[m], robot_free[r.robot]),
                                            24'(rt_time[idx]));
                    end
                    e.finish_time = mach_free[m];
                    e.chosen_machine = 4'(m);
                    job_ready[r.job] = mach_free[m];
                    job_loc[r.job] = 4'(m);
                    job_done[r.job] = 5'(job_done[r.job] + 1);
                    span = tmax(span, mach_free[m]);
                end
                e.makespan = span;
                e.sequence_done = r.last;
                expected_q.insert(expected_q.size(), e);
                if (r.last) clear_run();
            end
        endcase
    endtask

    initial begin
        for (int i = 0; i < NJ*NS; i++) alt_cnt[i] = '0;
        for (int i = 0; i < NJ*NS*NA; i++) begin
            rt_mach[i] = '0;
            rt_time[i] = '0;
        end
        for (int i = 0; i < NM*NM; i++) travel[i] = '0;
        clear_run();
    end

    assign pending = expected_q.size();

    always @(posedge aclk) begin
        res_t e;
        if (!aresetn) begin
            fail_count <= 0;
            results_seen <= 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0) begin
                    $error("result with no request waiting: %p", m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (m_data !== e) begin
                        fail_count <= fail_count + 1;
                        if (m_data.makespan !== e.makespan)
                            $error("makespan expected %0d actual %0d", e.makespan, m_data.makespan);
                        if (m_data.finish_time !== e.finish_time)
                            $error("finish_time expected %0d actual %0d",
                                   e.finish_time, m_data.finish_time);
                        if (m_data.chosen_machine !== e.chosen_machine)
                            $error("chosen_machine expected %0d actual %0d",
                                   e.chosen_machine, m_data.chosen_machine);
                        if (m_data.sequence_done !== e.sequence_done)
                            $error("sequence_done expected %0d actual %0d",
                                   e.sequence_done, m_data.sequence_done);
                        if (m_data.bad_step !== e.bad_step)
                            $error("bad_step expected %0d actual %0d", e.bad_step, m_data.bad_step);
                    end
                end
            end
            if (s_valid && s_ready) predict_request(s_data);
        end
    end
endmodule

>>> dv/schedule_makespan_evaluator_tb.sv
// Testbench top for the schedule makespan evaluator: drives load and evaluate
// requests with random gaps and stalls. Depends on sme_pkg and the checker.
`timescale 1ns / 1ps
module schedule_makespan_evaluator_tb;
    import sme_pkg::*;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    res_t m_data;
    int   fail_count, pending, results_seen;
    int   cycles = 0;
    int   n_loads = 0, n_evals = 0;
    bit   stim_done = 1'b0;
    bit   calm = 1'b0;
    // which (job, step) counts are known nonzero, so an evaluate never hits an
    // unwritten route entry; travel table is filled completely up front
    bit   step_live [16][16];

    localparam int LIMIT = 2_000_000;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    schedule_makespan_evaluator uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    schedule_makespan_evaluator_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
    );

    // Hold one request until it is taken; drop valid only over a gap.
    task automatic send(req_t r);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data <= r;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (op_t'(r.operation) == OP_EVAL) n_evals++;
        else n_loads++;
    endtask

    function automatic req_t rand_fill();
        req_t r;
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        r = raw[$bits(req_t)-1:0];
        return r;
    endfunction

    task automatic load_route(int j, int s, int a, int m, int t);
        req_t r;
        r = rand_fill();
        r.operation = OP_ROUTE;
        r.job = 4'(j); r.step_index = 4'(s); r.alt_choice = 8'(a);
        r.machine = 4'(m); r.value = 16'(t);
        send(r);
    endtask

    task automatic load_count(int j, int s, int c);
        req_t r;
        r = rand_fill();
        r.operation = OP_COUNT;
        r.job = 4'(j); r.step_index = 4'(s); r.value = 16'(c);
        send(r);
        step_live[j][s] = (c != 0);
    endtask

    task automatic load_travel(int a, int b, int t);
        req_t r;
        r = rand_fill();
        r.operation = OP_TRAVEL;
        r.machine = 4'(a); r.to_machine = 4'(b); r.value = 16'(t);
        send(r);
    endtask

    // Fill a step with all four alternatives, then set its count.
    task automatic load_step(int j, int s, int c, bit big);
        for (int a = 0; a < 4; a++)
            load_route(j, s, a, $urandom_range(0, 15),
                       big ? $urandom_range(0, 65535) : $urandom_range(0, 300));
        load_count(j, s, c);
    endtask

    task automatic evaluate(int j, int alt, int rb, bit lst);
        req_t r;
        r = rand_fill();
        r.operation = OP_EVAL;
        r.job = 4'(j); r.alt_choice = 8'(alt); r.robot = 2'(rb); r.last = lst;
        send(r);
    endtask

    // Result side: draw a stall per result, drop ready while stalled.
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            stall = calm ? 0 : $urandom_range(0, 13);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        int j, n;
        for (int a = 0; a < 16; a++)
            for (int b = 0; b < 16; b++) step_live[a][b] = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: full travel table with an extreme corner, then a few steps.
        for (int a = 0; a < 16; a++)
            for (int b = 0; b < 16; b++)
                load_travel(a, b, (a == 15 && b == 0) ? 16'hFFFF : $urandom_range(0, 40));
        load_route(0, 0, 0, 0, 16'hFFFF);
        load_count(0, 0, 1);               // same place: job starts at machine 0
        load_step(0, 1, 7, 1'b1);          // count above four clamps
        load_step(15, 0, 3, 1'b0);
        load_count(15, 1, 0);              // absent step
        evaluate(0, 255, 3, 1'b0);
        evaluate(0, 254, 0, 1'b0);
        evaluate(0, 0, 1, 1'b0);           // missing step
        evaluate(15, 200, 2, 1'b0);
        evaluate(15, 1, 2, 1'b0);          // missing step
        evaluate(1, 0, 0, 1'b1);           // never loaded, ends sequence
        // Saturation: hammer one machine with max times.
        for (int s = 0; s < 16; s++) begin
            load_route(2, s, 0, 15, 16'hFFFF);
            load_count(2, s, 1);
        end
        for (int k = 0; k < 16; k++) evaluate(2, k, k % 4, 1'b0);
        evaluate(2, 0, 0, 1'b1);           // step count exhausted

        // Random: mostly well-formed sequences, plus noise loads.
        for (int it = 0; it < 18; it++) begin
            calm = ($urandom_range(0, 7) == 0);
            n = $urandom_range(1, 2);
            for (int k = 0; k < n; k++) begin
                j = $urandom_range(0, 15);
                for (int s = 0; s < 16; s++)
                    if ($urandom_range(0, 3) == 0 || !step_live[j][s])
                        load_step(j, s, $urandom_range(0, 5), $urandom_range(0, 9) == 0);
            end
            if ($urandom_range(0, 2) == 0)
                load_travel($urandom_range(0, 15), $urandom_range(0, 15),
                            $urandom_range(0, 65535));
            n = $urandom_range(1, 40);
            for (int k = 0; k < n; k++)
                evaluate($urandom_range(0, 15), $urandom_range(0, 255),
                         $urandom_range(0, 3), k == n - 1 || $urandom_range(0, 40) == 0);
        end
        s_valid <= 1'b0;
        calm = 1'b0;
        stim_done = 1'b1;
    end

    // Watchdog and verdict.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("Sent %0d load and %0d evaluate requests; %0d results checked.",
                 n_loads, n_evals, results_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
